[rtl/core/assert_macros.svh]
// Assertion helpers used by lzss_dp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define LZ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define LZ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lzss_pkg.sv]
package lzss_pkg;

	localparam logic [7:0] FILL_BYTE    = 8'h20;
	localparam int         MAX_RUN      = 18;
	localparam int         PAIR_MIN_LEN = 3;
	localparam logic [3:0] FLAG_ITEMS   = 4'd8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LIT,
		ST_RD,
		ST_CP
	} state_t;

	typedef struct packed {
		logic clr;
		logic take_flag;
		logic take_low;
		logic take_high;
		logic take_lit;
		logic emit_lit;
		logic emit_copy;
		logic rd;
	} cmd_t;

	typedef struct packed {
		logic need_flag;
		logic await_high;
		logic lit_flag;
		logic clr_last;
		logic run_done;
		logic slot_free;
	} sts_t;

endpackage

[rtl/core/lzss_ctrl.sv]
module lzss_ctrl
	import lzss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && !sts.need_flag) begin
					if (sts.await_high) state_d = ST_RD;
					else if (sts.lit_flag) state_d = ST_LIT;
				end
			end
			ST_LIT: begin
				if (sts.slot_free) state_d = ST_IDLE;
			end
			ST_RD: begin
				state_d = ST_CP;
			end
			ST_CP: begin
				if (sts.slot_free && sts.run_done) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.need_flag) cmd.take_flag = 1'b1;
					else if (sts.await_high) cmd.take_high = 1'b1;
					else if (sts.lit_flag) cmd.take_lit = 1'b1;
					else cmd.take_low = 1'b1;
				end
			end
			ST_LIT: begin
				cmd.emit_lit = sts.slot_free;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
			end
			ST_CP: begin
				cmd.emit_copy = sts.slot_free;
				cmd.rd        = sts.slot_free && !sts.run_done;
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/lzss_dp.sv]
`include "assert_macros.svh"

module lzss_dp
	import lzss_pkg::*;
#(
	parameter int RING_DEPTH = 2048
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       run_last,
	input  cmd_t       cmd,
	output sts_t       sts
);

	localparam int          AW      = $clog2(RING_DEPTH);
	localparam logic [12:0] DEPTH13 = 13'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
	localparam logic [AW-1:0] WP_RESET  = AW'(RING_DEPTH - MAX_RUN);

	logic [7:0]    mem [RING_DEPTH];
	logic [7:0]    rdata_q;
	logic [7:0]    flags_q;
	logic [3:0]    left_q;
	logic [7:0]    low_q;
	logic          await_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] clr_q;
	logic [4:0]    cnt_q;
	logic          fwd_q;
	logic [7:0]    last_q;
	logic [7:0]    lit_q;
	logic          ov_q;
	logic [7:0]    ob_q;
	logic          ol_q;

	logic [11:0]   off12;
	logic [11:0]   off_mod;
	logic [7:0]    cbyte;
	logic          we;
	logic [AW-1:0] wa;
	logic [7:0]    wd;

	function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : a + 1'b1;
	endfunction

	assign off12   = {in_byte[7:4], low_q};
	assign off_mod = ({1'b0, off12} >= DEPTH13) ? off12 - DEPTH13[11:0] : off12;
	assign cbyte   = fwd_q ? last_q : rdata_q;

	assign we = cmd.clr || cmd.emit_lit || cmd.emit_copy;
	assign wa = cmd.clr ? clr_q : wp_q;
	assign wd = cmd.clr ? FILL_BYTE : (cmd.emit_lit ? lit_q : cbyte);

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (cmd.rd) rdata_q <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			left_q  <= '0;
			low_q   <= '0;
			await_q <= 1'b0;
			wp_q    <= WP_RESET;
			rd_q    <= '0;
			clr_q   <= '0;
			cnt_q   <= '0;
			fwd_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.clr) clr_q <= inc_wrap(clr_q);
			if (cmd.take_flag) begin
				flags_q <= in_byte;
				left_q  <= FLAG_ITEMS;
				await_q <= 1'b0;
			end
			if (cmd.take_low) begin
				low_q   <= in_byte;
				await_q <= 1'b1;
			end
			if (cmd.take_high || cmd.take_lit) begin
				flags_q <= flags_q >> 1;
				if (left_q != 4'd0) left_q <= left_q - 4'd1;
			end
			if (cmd.take_high) begin
				await_q <= 1'b0;
				rd_q    <= AW'(off_mod);
				cnt_q   <= 5'({1'b0, in_byte[3:0]} + 5'(PAIR_MIN_LEN - 1));
			end
			if (cmd.rd) begin
				rd_q  <= inc_wrap(rd_q);
				fwd_q <= cmd.emit_copy && (rd_q == wp_q);
			end
			if (cmd.emit_copy && cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
			if (cmd.emit_lit || cmd.emit_copy) begin
				wp_q <= inc_wrap(wp_q);
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_lit) lit_q <= in_byte;
		if (cmd.emit_copy) last_q <= cbyte;
		if (cmd.emit_lit) begin
			ob_q <= lit_q;
			ol_q <= 1'b1;
		end else if (cmd.emit_copy) begin
			ob_q <= cbyte;
			ol_q <= (cnt_q == 5'd0);
		end
	end

	assign sts.need_flag  = (left_q == 4'd0);
	assign sts.await_high = await_q;
	assign sts.lit_flag   = flags_q[0];
	assign sts.clr_last   = (clr_q == LAST_ADDR);
	assign sts.run_done   = (cnt_q == 5'd0);
	assign sts.slot_free  = !ov_q || out_ready;

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign run_last  = ol_q;

	`LZ_ASSERT(a_no_overrun, (cmd.emit_lit || cmd.emit_copy) |-> (!ov_q || out_ready), "output overwritten")
	`LZ_ASSERT(a_left_range, left_q <= FLAG_ITEMS, "flag count out of range")
	`LZ_ASSERT(a_copy_reads, (cmd.emit_copy && cnt_q != 5'd0) |-> cmd.rd, "copy emitted without next read")
	`LZ_ASSERT_ALWAYS(a_one_writer, !(cmd.clr && (cmd.emit_lit || cmd.emit_copy)), "ring write conflict")

endmodule

[rtl/core/lzss_ring_decompress_unit.sv]
// channel | signals                       | direction
// in      | in_valid, in_ready, in_byte   | compressed bytes into the unit
// out     | out_valid, out_ready,         | decompressed bytes out of the unit
//         | out_byte, run_last            |
// After reset the ring is swept to spaces, one entry a cycle, and no input is taken.
// Flag and pair low bytes are only taken in; a literal is taken in, then written to the ring.
// A pair is taken in, then the first ring read is made, then its bytes are copied.
// Copy bytes go one a cycle while the output is free, each read and written back to the ring.
// A stalled output holds the copy in place; no ring access advances until a beat moves.
module lzss_ring_decompress_unit
	import lzss_pkg::*;
#(
	parameter int RING_DEPTH = 2048
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	cmd_t cmd;
	sts_t sts;

	lzss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzss_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[bench/lzss_ring_decompress_unit_tb.sv]
`timescale 1ns / 1ps

module lzss_ring_decompress_unit_tb;
	import lzss_pkg::*;

	localparam int RING_DEPTH  = 2048;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_ITEMS  = 196;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	class decoded_byte_board;
		out_beat_t  expected_bytes[$];
		logic [7:0] ring [RING_DEPTH];
		int unsigned wptr;
		logic [7:0] type_flags;
		logic [3:0] flags_left;
		logic [7:0] pair_low;
		logic       awaiting;
		int         mismatches;

		function new();
			for (int i = 0; i < RING_DEPTH; i++)
				ring[i] = FILL_BYTE;
			wptr       = RING_DEPTH - MAX_RUN;
			type_flags = '0;
			flags_left = '0;
			pair_low   = '0;
			awaiting   = 1'b0;
			mismatches = 0;
		endfunction

		function void advance_item();
			type_flags = type_flags >> 1;
			if (flags_left != 0)
				flags_left = flags_left - 1;
		endfunction

		function void store_byte(logic [7:0] c, logic l);
			out_beat_t e;
			ring[wptr] = c;
			wptr = (wptr + 1) % RING_DEPTH;
			e.data = c;
			e.last = l;
			expected_bytes.push_back(e);
		endfunction

		function void take_code_byte(logic [7:0] b);
			int unsigned off;
			int unsigned len;
			if (flags_left == 0) begin
				type_flags = b;
				flags_left = FLAG_ITEMS;
				awaiting   = 1'b0;
			end else if (awaiting) begin
				off = {b[7:4], pair_low} % RING_DEPTH;
				len = b[3:0] + PAIR_MIN_LEN;
				for (int k = 0; k < len; k++)
					store_byte(ring[(off + k) % RING_DEPTH], k + 1 == len);
				awaiting = 1'b0;
				advance_item();
			end else if (type_flags[0]) begin
				store_byte(b, 1'b1);
				advance_item();
			end else begin
				pair_low = b;
				awaiting = 1'b1;
			end
		endfunction

		function void check_out_beat(logic [7:0] d, logic l);
			out_beat_t e;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual out_byte %02h run_last %0b",
					$time, d, l);
				mismatches++;
				return;
			end
			e = expected_bytes.pop_front();
			if (d !== e.data) begin
				$display("%0t: out_byte expected %02h actual %02h", $time, e.data, d);
				mismatches++;
			end
			if (l !== e.last) begin
				$display("%0t: run_last expected %0b actual %0b", $time, e.last, l);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;

	decoded_byte_board sb = new();

	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	int hold_left = 0;
	int phase_left = 0;
	int stall_mode = 0;
	bit hold_start = 1'b0;
	logic [3:0] planned_hi = '0;

	lzss_ring_decompress_unit #(.RING_DEPTH(RING_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.run_last (run_last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lzss_ring_decompress_unit_tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_out_beat(out_byte, run_last);
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(5, 60);
				stall_mode = $urandom_range(0, 2);
			end
			phase_left--;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic push_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_code_byte(b);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
				: $urandom_range(0, 10);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic push_random_item();
		logic [7:0]  b;
		int unsigned off;
		if ($urandom_range(0, 11) == 0) begin
			b = $urandom_range(0, 255);
		end else if (sb.flags_left == 0) begin
			case ($urandom_range(0, 3))
				0: b = 8'hFF;
				1: b = 8'h00;
				default: b = $urandom_range(0, 255);
			endcase
		end else if (sb.awaiting) begin
			b = {planned_hi, 4'($urandom_range(0, 15))};
		end else if (sb.type_flags[0]) begin
			b = $urandom_range(0, 255);
		end else begin
			if ($urandom_range(0, 2) == 0)
				off = $urandom_range(0, RING_DEPTH - 1);
			else
				off = (sb.wptr + RING_DEPTH - $urandom_range(1, 40)) % RING_DEPTH;
			planned_hi = {1'($urandom_range(0, 1)), off[10:8]};
			b = off[7:0];
		end
		push_byte(b);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two literals then six pairs: overlap, spaces, top of ring, wrap; then a flag byte and eight literals
		push_byte(8'b0000_0011);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'hEE);
		push_byte(8'h71);
		push_byte(8'h00);
		push_byte(8'h0F);
		push_byte(8'hFF);
		push_byte(8'hF0);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'h12);
		push_byte(8'h34);
		push_byte(8'hAB);
		push_byte(8'hCD);
		push_byte(8'hFF);
		push_byte(8'h55);
		push_byte(8'hAA);
		push_byte(8'h01);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(8'hFE);
		push_byte(8'h20);
		push_byte(8'h00);

		while (items_sent < 24 + RAND_ITEMS) begin
			if (items_sent == 100)
				hold_start = 1'b1;
			if (items_sent == 170)
				drain_results();
			push_random_item();
		end

		// leave a half pair pending at end of stream
		while (sb.flags_left == 0 || sb.awaiting || sb.type_flags[0]) begin
			if (sb.flags_left == 0)
				push_byte(8'h00);
			else
				push_byte($urandom_range(0, 255));
		end
		push_byte(8'hC3);

		drain_results();
		repeat (2 * MAX_RUN + 4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("lzss_ring_decompress_unit_tb: PASS");
		else
			$display("lzss_ring_decompress_unit_tb: FAIL");
		$finish;
	end

endmodule
